/* rtl/core/cluster_key_slot_hash_top_defines.svh */
// Assertion macros shared by the cluster key slot hash RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CLUSTER_KEY_SLOT_HASH_TOP_DEFINES_SVH
`define CLUSTER_KEY_SLOT_HASH_TOP_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define CKSH_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CKSH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/cksh_pkg.sv */
// Package for the cluster key slot hash block: beat types, constants, CRC16 step.
// No dependencies; used by the hash, checker, queue and top modules and by the bench.
package cksh_pkg;

   localparam int SLOT_BITS_DEFAULT = 14;
   localparam int SLOT_FIELD_BITS   = 14;
   localparam int CRC_BITS          = 16;

   localparam logic [CRC_BITS-1:0] CRC_POLY    = 16'h1021;
   localparam logic [7:0]          BRACE_OPEN  = 8'h7B;
   localparam logic [7:0]          BRACE_CLOSE = 8'h7D;

   // Register map
   localparam logic REG_CLUSTER_ENABLED = 1'b0;

   typedef struct packed {
      logic [7:0] key_byte;
      logic       last_of_key;
      logic       first_of_group;
   } req_beat_type;

   typedef struct packed {
      logic [SLOT_FIELD_BITS-1:0] slot;
      logic                       unique_valid;
      logic [SLOT_FIELD_BITS-1:0] unique_slot;
      logic                       cross_slot;
   } rsp_beat_type;

   // CRC16-XMODEM over one byte, MSB first
   function automatic logic [CRC_BITS-1:0] crc16_byte(input logic [CRC_BITS-1:0] crc,
                                                      input logic [7:0]          data);
      logic [CRC_BITS-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_BITS-1]) begin
            c = {c[CRC_BITS-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_BITS-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/cksh_chan_if.sv */
// Valid/ready channel interface carrying one payload beat.
// Payload type is supplied by the instantiating scope (types from cksh_pkg).
interface cksh_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/cksh_key_hash.sv */
// Per-key hashing: whole-key CRC, hash tag tracking and tag CRC, slot select.
// Depends on cksh_pkg.
module cksh_key_hash #(
   parameter int SLOT_BITS = cksh_pkg::SLOT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  cksh_pkg::req_beat_type beat,
   output logic [SLOT_BITS-1:0] slot
);
   import cksh_pkg::*;

   typedef enum logic [1:0] {
      PH_SEEK,
      PH_IN,
      PH_DONE
   } phase_type;

   logic [CRC_BITS-1:0] crc_whole_ff, crc_whole_in;
   logic [CRC_BITS-1:0] crc_tag_ff, crc_tag_in;
   phase_type           phase_ff, phase_in;
   logic                has_bytes_ff, has_bytes_in;

   logic [CRC_BITS-1:0] base_whole, base_tag, crc_sel;
   phase_type           base_phase;
   logic                base_has;

   // Group start restarts the key; then fold in this byte
   always_comb begin
      base_whole = beat.first_of_group ? '0 : crc_whole_ff;
      base_tag   = beat.first_of_group ? '0 : crc_tag_ff;
      base_phase = beat.first_of_group ? PH_SEEK : phase_ff;
      base_has   = beat.first_of_group ? 1'b0 : has_bytes_ff;

      crc_whole_in = crc16_byte(base_whole, beat.key_byte);
      crc_tag_in   = base_tag;
      phase_in     = base_phase;
      has_bytes_in = base_has;

      unique case (base_phase)
         PH_SEEK: begin
            if (beat.key_byte == BRACE_OPEN) begin
               phase_in = PH_IN;
            end
         end
         PH_IN: begin
            if (beat.key_byte == BRACE_CLOSE) begin
               phase_in = PH_DONE;
            end else begin
               crc_tag_in   = crc16_byte(base_tag, beat.key_byte);
               has_bytes_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Non-empty closed tag wins, otherwise whole key
      crc_sel = (phase_in == PH_DONE && has_bytes_in) ? crc_tag_in : crc_whole_in;
      slot    = crc_sel[SLOT_BITS-1:0];
   end

   // Key state; cleared after the last byte of a key
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_whole_ff <= '0;
         crc_tag_ff   <= '0;
         phase_ff     <= PH_SEEK;
         has_bytes_ff <= 1'b0;
      end else if (accept) begin
         if (beat.last_of_key) begin
            crc_whole_ff <= '0;
            crc_tag_ff   <= '0;
            phase_ff     <= PH_SEEK;
            has_bytes_ff <= 1'b0;
         end else begin
            crc_whole_ff <= crc_whole_in;
            crc_tag_ff   <= crc_tag_in;
            phase_ff     <= phase_in;
            has_bytes_ff <= has_bytes_in;
         end
      end
   end

endmodule

/* rtl/core/cksh_group_check.sv */
// Group checker: tracks whether all recorded keys of a group share one slot,
// and assembles the result beat. Depends on cksh_pkg and the defines header.
`include "cluster_key_slot_hash_top_defines.svh"

module cksh_group_check #(
   parameter int SLOT_BITS = cksh_pkg::SLOT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   first_of_group,
   input  logic                   last_of_key,
   input  logic                   cluster_enabled,
   input  logic [SLOT_BITS-1:0]   slot,
   output cksh_pkg::rsp_beat_type rsp_beat
);
   import cksh_pkg::*;

   typedef enum logic [1:0] {
      GS_NONE,
      GS_ONE,
      GS_CROSS
   } status_type;

   status_type           status_ff, status_in, base_status;
   logic [SLOT_BITS-1:0] group_slot_ff, group_slot_in, base_slot;

   // Next checker state as seen by this beat
   always_comb begin
      base_status   = first_of_group ? GS_NONE : status_ff;
      base_slot     = first_of_group ? '0 : group_slot_ff;
      status_in     = base_status;
      group_slot_in = base_slot;
      if (last_of_key && cluster_enabled) begin
         unique case (base_status)
            GS_NONE: begin
               status_in     = GS_ONE;
               group_slot_in = slot;
            end
            GS_ONE: begin
               if (base_slot != slot) begin
                  status_in = GS_CROSS;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result beat reports the updated status
   always_comb begin
      rsp_beat.slot         = SLOT_FIELD_BITS'(slot);
      rsp_beat.unique_valid = (status_in == GS_ONE);
      rsp_beat.unique_slot  = (status_in == GS_ONE) ? SLOT_FIELD_BITS'(group_slot_in) : '0;
      rsp_beat.cross_slot   = (status_in == GS_CROSS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= GS_NONE;
         group_slot_ff <= '0;
      end else if (accept) begin
         status_ff     <= status_in;
         group_slot_ff <= group_slot_in;
      end
   end

   `CKSH_ASSERT_ALWAYS(a_excl_flags, clock, reset, !(rsp_beat.unique_valid && rsp_beat.cross_slot), "unique and cross slot both set")
   `CKSH_ASSERT_NEXT(a_group_clear, clock, reset, accept && first_of_group && !last_of_key, status_ff == GS_NONE, "group start did not clear checker")
   `CKSH_ASSERT_NEXT(a_cross_sticky, clock, reset, status_ff == GS_CROSS && !(accept && first_of_group), status_ff == GS_CROSS, "cross slot dropped without group start")

endmodule

/* rtl/core/cksh_out_queue.sv */
// Two-entry result queue between the hash logic and the result channel.
// Depends on cksh_pkg and the defines header.
`include "cluster_key_slot_hash_top_defines.svh"

module cksh_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cksh_pkg::rsp_beat_type push_beat,
   output logic                   full,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cksh_pkg::rsp_beat_type out_beat
);
   import cksh_pkg::*;

   rsp_beat_type entries_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_beat  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_beat;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   `CKSH_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff != 2'd3, "queue count out of range")
   `CKSH_ASSERT_ALWAYS(a_no_overflow, clock, reset, !(push && full), "push into full queue")
   `CKSH_ASSERT_NEXT(a_full_holds, clock, reset, full && !pop, full, "full queue lost an entry")

endmodule

/* rtl/core/cluster_key_slot_hash_top.sv */
// A key's result beat is written into the result queue when its last byte is accepted.
// Throughput: one key byte per cycle; the two-entry result queue keeps bytes
// flowing while a result waits, and input stalls only when both entries are full.
// Reset (synchronous): clears key and group state, empties the queue and
// sets cluster_enabled to 0.
module cluster_key_slot_hash_top #(
   parameter int SLOT_BITS = cksh_pkg::SLOT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cksh_chan_if.sink   req_bus,
   cksh_chan_if.source rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import cksh_pkg::*;

   logic                 cluster_enabled_ff;
   logic                 accept;
   logic                 queue_full;
   logic [SLOT_BITS-1:0] key_slot;
   req_beat_type         req_beat;
   rsp_beat_type         new_beat;
   rsp_beat_type         out_beat;

   // Configuration register
   assign pready = 1'b1;
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_CLUSTER_ENABLED) begin
         prdata = {31'd0, cluster_enabled_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_enabled_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready
                   && paddr[2] == REG_CLUSTER_ENABLED) begin
         cluster_enabled_ff <= pwdata[0];
      end
   end

   // Input handshake
   assign req_beat      = req_bus.data;
   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;

   cksh_key_hash #(
      .SLOT_BITS (SLOT_BITS)
   ) u_key_hash (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .beat   (req_beat),
      .slot   (key_slot)
   );

   cksh_group_check #(
      .SLOT_BITS (SLOT_BITS)
   ) u_group_check (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .first_of_group  (req_beat.first_of_group),
      .last_of_key     (req_beat.last_of_key),
      .cluster_enabled (cluster_enabled_ff),
      .slot            (key_slot),
      .rsp_beat        (new_beat)
   );

   // Result beats only on the last byte of a key
   cksh_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && req_beat.last_of_key),
      .push_beat (new_beat),
      .full      (queue_full),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_beat  (out_beat)
   );

   assign rsp_bus.data = out_beat;

endmodule

/* verif/tb_top.sv */
// Self-checking bench for cluster_key_slot_hash_top: streams key bytes, predicts slots and
// group status, and checks every result beat. Depends on cksh_pkg and cksh_chan_if.
`timescale 1ns / 1ps

module tb_top;
   import cksh_pkg::*;

   typedef logic [7:0] byte_q_type[$];
   typedef enum logic [1:0] {TAG_SEEK, TAG_OPEN, TAG_CLOSED} tag_phase_type;
   typedef enum logic [1:0] {GROUP_EMPTY, GROUP_SAME, GROUP_SPLIT} group_state_type;

   localparam logic [2:0] CSR_ADDR_CLUSTER_ENABLED = 3'(4 * REG_CLUSTER_ENABLED);
   localparam logic [2:0] CSR_ADDR_UNMAPPED        = 3'd4;
   localparam int         STUCK_LIMIT              = 2000;
   localparam int         PHASE_BYTES              = 290;
   localparam int         PHASE_GAP [4]            = '{0, 78, 0, 6};
   localparam int         PHASE_STALL [4]          = '{0, 0, 78, 6};
   localparam bit         PHASE_ENABLE [4]         = '{1'b1, 1'b0, 1'b1, 1'b1};

   // Slot predictor: tracks whole-key and tag CRCs plus the group checker
   class slot_scoreboard_type;
      bit              enabled;
      logic [15:0]     crc_key;
      logic [15:0]     crc_tag;
      tag_phase_type   phase;
      bit              tag_nonempty;
      group_state_type group_state;
      logic [SLOT_FIELD_BITS-1:0] group_slot;
      rsp_beat_type    slot_q[$];
      int unsigned     mismatches;

      function new();
         enabled     = 1'b0;
         group_state = GROUP_EMPTY;
         group_slot  = '0;
         mismatches  = 0;
         clear_key();
      endfunction

      function void clear_key();
         crc_key      = '0;
         crc_tag      = '0;
         phase        = TAG_SEEK;
         tag_nonempty = 1'b0;
      endfunction

      // CRC16-XMODEM, one bit at a time, MSB first
      static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
               c = c ^ CRC_POLY;
            end
         end
         return c;
      endfunction

      function void set_register(int unsigned index, logic [31:0] value);
         if (index == REG_CLUSTER_ENABLED) begin
            enabled = value[0];
         end
      endfunction

      function void note_byte(req_beat_type beat);
         rsp_beat_type want;
         logic [15:0]  chosen;
         logic [15:0]  slot_mask;
         slot_mask = 16'((32'd1 << SLOT_BITS_DEFAULT) - 32'd1);
         if (beat.first_of_group) begin
            group_state = GROUP_EMPTY;
            group_slot  = '0;
            clear_key();
         end
         crc_key = crc_step(crc_key, beat.key_byte);
         case (phase)
            TAG_SEEK: begin
               if (beat.key_byte == BRACE_OPEN) phase = TAG_OPEN;
            end
            TAG_OPEN: begin
               if (beat.key_byte == BRACE_CLOSE) begin
                  phase = TAG_CLOSED;
               end else begin
                  crc_tag      = crc_step(crc_tag, beat.key_byte);
                  tag_nonempty = 1'b1;
               end
            end
            default: ;
         endcase
         if (!beat.last_of_key) return;

         // empty or unclosed tag falls back to the whole key
         chosen    = (phase == TAG_CLOSED && tag_nonempty) ? crc_tag : crc_key;
         want.slot = SLOT_FIELD_BITS'(chosen & slot_mask);
         if (enabled) begin
            if (group_state == GROUP_EMPTY) begin
               group_state = GROUP_SAME;
               group_slot  = want.slot;
            end else if (group_state == GROUP_SAME && group_slot != want.slot) begin
               group_state = GROUP_SPLIT;
            end
         end
         want.unique_valid = (group_state == GROUP_SAME);
         want.unique_slot  = (group_state == GROUP_SAME) ? group_slot : '0;
         want.cross_slot   = (group_state == GROUP_SPLIT);
         slot_q.push_back(want);
         clear_key();
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (slot_q.size() == 0) begin
            $error("unexpected result beat: slot %0d", got.slot);
            mismatches++;
            return;
         end
         want = slot_q.pop_front();
         compare_field("slot", want.slot, got.slot);
         compare_field("unique_valid", want.unique_valid, got.unique_valid);
         compare_field("unique_slot", want.unique_slot, got.unique_slot);
         compare_field("cross_slot", want.cross_slot, got.cross_slot);
      endfunction

      function int unsigned pending();
         return slot_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          gap_pct = 0;
   int          stall_pct = 0;
   int          sent_in_phase = 0;
   int          stuck_cycles = 0;

   slot_scoreboard_type sb = new();

   cksh_chan_if #(.payload_type(req_beat_type)) req_bus ();
   cksh_chan_if #(.payload_type(rsp_beat_type)) rsp_bus ();

   cluster_key_slot_hash_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: random back-pressure and checking of accepted beats
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_result(rsp_bus.data);
      end
   end

   // Watchdog: too long without any beat moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("cluster_key_slot_hash_top regression: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // One key byte, after an optional random gap
   task automatic send_beat(input logic [7:0] b, input bit last, input bit first);
      req_beat_type beat;
      beat = '{key_byte: b, last_of_key: last, first_of_group: first};
      if ($urandom_range(0, 99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= beat;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_byte(beat);
      sent_in_phase++;
   endtask

   // first_at marks the byte carrying first_of_group (-1: none)
   task automatic send_bytes(input byte_q_type key, input int first_at, input bit finish);
      for (int i = 0; i < key.size(); i++) begin
         send_beat(key[i], finish && (i == key.size() - 1), i == first_at);
      end
   endtask

   function automatic byte_q_type text_bytes(string s);
      byte_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // Biased toward braces and a tiny alphabet so tags and slot collisions show up
   function automatic logic [7:0] rand_key_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return BRACE_OPEN;
      if (r < 30) return BRACE_CLOSE;
      if (r < 55) return 8'(8'h61 + $urandom_range(0, 3));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = rand_key_byte();
      if (b == BRACE_OPEN || b == BRACE_CLOSE) b = 8'($urandom_range(0, 122));
      return b;
   endfunction

   // Sender holds off until every expected result has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(addr >> 2, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // One command group: mostly keys sharing a hash tag, else brace-heavy noise
   task automatic send_group();
      byte_q_type tag;
      byte_q_type key;
      int         n_keys;
      int         noise;
      int         first_at;
      bit         shared;
      bit         restart;
      n_keys  = $urandom_range(1, 4);
      shared  = ($urandom_range(0, 99) < 55);
      restart = 1'b1;
      repeat ($urandom_range(1, 3)) tag.push_back(plain_byte());
      for (int k = 0; k < n_keys; k++) begin
         key = {};
         if (shared) begin
            repeat ($urandom_range(0, 2)) key.push_back(plain_byte());
            key.push_back(BRACE_OPEN);
            key = {key, tag};
            key.push_back(BRACE_CLOSE);
            repeat ($urandom_range(0, 2)) key.push_back(rand_key_byte());
         end else begin
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8))
               key.push_back(rand_key_byte());
         end
         noise = $urandom_range(0, 99);
         if (noise < 6) begin
            // key left open; the next key restarts the group
            send_bytes(key, restart ? 0 : -1, 1'b0);
            restart = 1'b1;
         end else begin
            first_at = restart ? 0 : ((noise < 12) ? int'($urandom_range(0, key.size() - 1)) : -1);
            send_bytes(key, first_at, 1'b1);
            restart = 1'b0;
         end
      end
   endtask

   initial begin
      bit paused;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: checker off after reset, then tag corner cases
      send_beat(8'h6B, 1'b1, 1'b1);
      csr_write(CSR_ADDR_CLUSTER_ENABLED, 32'h1);
      send_bytes(text_bytes("{}"), 0, 1'b1);       // empty tag hashes whole key
      send_bytes(text_bytes("{a}"), 0, 1'b1);      // closing brace as last byte
      send_bytes(text_bytes("b{a}}"), -1, 1'b1);   // later brace is ordinary
      send_bytes(text_bytes("{q"), -1, 1'b1);      // unclosed brace
      send_bytes(text_bytes("zz"), -1, 1'b0);      // dropped by the group start
      send_beat(8'hFF, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(BRACE_CLOSE, 1'b1, 1'b0);          // cross slot stays set
      csr_write(CSR_ADDR_UNMAPPED, 32'h0);         // ignored
      send_bytes(text_bytes("{a}"), 0, 1'b1);
      csr_write(CSR_ADDR_CLUSTER_ENABLED, 32'hFFFF_FFFE);
      send_beat(BRACE_OPEN, 1'b1, 1'b0);           // checker frozen, status reported

      // Random phases with different idle patterns
      for (int p = 0; p < 4; p++) begin
         gap_pct   = PHASE_GAP[p];
         stall_pct = PHASE_STALL[p];
         csr_write(CSR_ADDR_CLUSTER_ENABLED, ($urandom() & ~32'h1) | 32'(PHASE_ENABLE[p]));
         sent_in_phase = 0;
         paused        = 1'b0;
         while (sent_in_phase < PHASE_BYTES) begin
            send_group();
            if (!paused && sent_in_phase >= PHASE_BYTES / 2) begin
               paused = 1'b1;
               drain();
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("cluster_key_slot_hash_top regression: pass");
      end else begin
         $display("cluster_key_slot_hash_top regression: fail");
      end
      $finish;
   end

endmodule
